/* sv/port_rule_classifier_dedup_unit_assert.svh */
// ----------------------------------------------------------------------------
// port_rule_classifier_dedup_unit_assert.svh
// assertion macros shared by the classifier rtl
// ----------------------------------------------------------------------------
`ifndef PORT_RULE_CLASSIFIER_DEDUP_UNIT_ASSERT_SVH
`define PORT_RULE_CLASSIFIER_DEDUP_UNIT_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define PRCD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising clock edge out of reset
`define PRCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/prcd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prcd_pkg
// widths, codes and types of the port rule classifier
// ----------------------------------------------------------------------------
package prcd_pkg;

    localparam int PROTO_W = 8;
    localparam int PORT_W  = 16;
    localparam int TIME_W  = 32;
    localparam int RIDX_W  = 4;

    // action codes of an input word
    localparam logic ACT_RULE = 1'b0;
    localparam logic ACT_PKT  = 1'b1;

    // one entry of the rule table
    typedef struct packed {
        logic [PROTO_W-1:0] proto;
        logic [PORT_W-1:0]  src_port;
        logic [PORT_W-1:0]  dst_port;
    } rule_t;

endpackage

/* sv/prcd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prcd_if
// valid/ready channels of the port rule classifier
// ----------------------------------------------------------------------------

// request channel: rule writes and packet headers
interface prcd_req_if;
    import prcd_pkg::*;

    logic               valid;
    logic               ready;
    logic               action;
    logic [RIDX_W-1:0]  rule_index;
    logic [PROTO_W-1:0] proto;
    logic [PORT_W-1:0]  src_port;
    logic [PORT_W-1:0]  dst_port;
    logic [TIME_W-1:0]  pkt_time;

    modport source (output valid, action, rule_index, proto, src_port, dst_port, pkt_time,
                    input ready);
    modport sink   (input valid, action, rule_index, proto, src_port, dst_port, pkt_time,
                    output ready);
endinterface

// response channel: one word per packet
interface prcd_rsp_if;
    import prcd_pkg::*;

    logic              valid;
    logic              ready;
    logic [RIDX_W-1:0] match_index;
    logic              suppressed;

    modport source (output valid, match_index, suppressed, input ready);
    modport sink   (input valid, match_index, suppressed, output ready);
endinterface

// configuration write channel: dedup window
interface prcd_cfg_if;
    import prcd_pkg::*;

    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] dedup_window;

    modport source (output valid, dedup_window, input ready);
    modport sink   (input valid, dedup_window, output ready);
endinterface

/* sv/port_rule_classifier_dedup_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// port_rule_classifier_dedup_unit
// wildcard port rule classifier with duplicate packet suppression
// ----------------------------------------------------------------------------
// req: a word with action 0 writes proto/src_port/dst_port into rule
//   rule_index (ignored beyond the table); a word with action 1 is a packet
//   header with a timestamp. cfg: writes the dedup window, always ready.
// rsp: one word per packet, match_index and suppressed.
// A rule write lands when the word is accepted. A packet is registered,
// passes S_LOAD, gets the duplicate check in S_CHECK, then (unless a
// duplicate) one sweep of NUM_RULES reads through the single read port of
// the rule memory in S_SCAN, the last read in S_LAST, and the result is
// loaded in S_OUT; a duplicate goes from S_CHECK to S_OUT. Both match passes are
// evaluated on the same sweep. req.ready is high only when no packet is in
// work, so packets go one at a time.
// Reset empties the table through per-entry valid bits (an unwritten entry
// reads as zero), clears the duplicate history and the window; the block is
// ready in the first cycle after reset.
// The result sits in an output register; a stalled receiver holds it, and
// the next packet waits for that register before its result is loaded.
// ----------------------------------------------------------------------------
`include "port_rule_classifier_dedup_unit_assert.svh"

module port_rule_classifier_dedup_unit #(
    parameter int NUM_RULES = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    prcd_req_if.sink   req,
    prcd_rsp_if.source rsp,
    prcd_cfg_if.sink   cfg
);
    import prcd_pkg::*;

    localparam int IDX_W = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_CHECK,
        S_SCAN,
        S_LAST,
        S_OUT
    } state_t;

    state_t               state_reg;
    logic [TIME_W-1:0]    window_reg;

    // rule memory and per-entry valid bits
    rule_t                rule_mem [NUM_RULES];
    logic [NUM_RULES-1:0] ent_valid_reg;
    rule_t                rd_data_reg;
    logic                 rd_ok_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    logic                 eval_en_reg;

    // registered packet
    logic [PROTO_W-1:0]   pkt_proto_reg;
    logic [PORT_W-1:0]    pkt_src_reg;
    logic [PORT_W-1:0]    pkt_dst_reg;
    logic [TIME_W-1:0]    pkt_time_reg;

    // duplicate history
    logic [TIME_W-1:0]    prev_time_reg;
    logic [TIME_W-1:0]    chk_time_reg;
    logic [PROTO_W-1:0]   chk_proto_reg;
    logic [PORT_W-1:0]    chk_src_reg;
    logic [PORT_W-1:0]    chk_dst_reg;

    // sweep state
    logic [IDX_W-1:0]     cnt_reg;
    logic                 hit1_found_reg;
    logic [IDX_W-1:0]     hit1_idx_reg;
    logic                 hit2_found_reg;
    logic [IDX_W-1:0]     hit2_idx_reg;
    logic                 res_dup_reg;

    // output register
    logic                 out_valid_reg;
    logic [RIDX_W-1:0]    out_index_reg;
    logic                 out_supp_reg;

    logic                 req_fire;
    logic                 rule_wr;
    logic [IDX_W-1:0]     wr_addr;
    logic [TIME_W-1:0]    gap_diff;
    logic [TIME_W-1:0]    dup_diff;
    logic                 check_run;
    logic                 is_dup;
    rule_t                ent;
    logic                 ent_p1;
    logic                 ent_p2;
    logic [IDX_W-1:0]     res_idx;
    logic                 out_free;

    // handshakes
    assign req.ready       = (state_reg == S_IDLE);
    assign cfg.ready       = 1'b1;
    assign req_fire        = req.valid && req.ready;
    assign rule_wr         = req_fire && (req.action == ACT_RULE)
                             && (32'(req.rule_index) < NUM_RULES);
    assign wr_addr         = IDX_W'(req.rule_index);
    assign rsp.valid       = out_valid_reg;
    assign rsp.match_index = out_index_reg;
    assign rsp.suppressed  = out_supp_reg;
    assign out_free        = !out_valid_reg || rsp.ready;

    // duplicate check on the registered packet
    assign gap_diff  = pkt_time_reg - prev_time_reg;
    assign dup_diff  = pkt_time_reg - chk_time_reg;
    assign check_run = gap_diff[TIME_W-1] || (gap_diff <= window_reg);
    assign is_dup    = check_run && (dup_diff <= window_reg)
                       && (pkt_proto_reg == chk_proto_reg)
                       && (pkt_src_reg == chk_src_reg)
                       && (pkt_dst_reg == chk_dst_reg)
                       && (pkt_src_reg != '0);

    // match test of the entry just read; unwritten entries read as zero
    always_comb
    begin
        ent    = rd_ok_reg ? rd_data_reg : '0;
        ent_p1 = (ent.proto == pkt_proto_reg)
                 && ((ent.src_port == '0) || (ent.src_port == pkt_src_reg))
                 && ((ent.dst_port == '0) || (ent.dst_port == pkt_dst_reg));
        ent_p2 = (ent.proto == pkt_proto_reg)
                 && ((ent.src_port == pkt_src_reg) || (ent.dst_port == pkt_dst_reg));
    end

    // pass one wins, then pass two, else entry zero
    always_comb
    begin
        priority if (hit1_found_reg)
            res_idx = hit1_idx_reg;
        else if (hit2_found_reg)
            res_idx = hit2_idx_reg;
        else
            res_idx = '0;
    end

    // rule memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (rule_wr)
        begin
            rule_mem[wr_addr] <= '{proto: req.proto, src_port: req.src_port,
                                   dst_port: req.dst_port};
        end
        rd_data_reg <= rule_mem[cnt_reg];
    end

    // state machine, history and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            window_reg     <= '0;
            ent_valid_reg  <= '0;
            rd_ok_reg      <= 1'b0;
            rd_idx_reg     <= '0;
            eval_en_reg    <= 1'b0;
            pkt_proto_reg  <= '0;
            pkt_src_reg    <= '0;
            pkt_dst_reg    <= '0;
            pkt_time_reg   <= '0;
            prev_time_reg  <= '0;
            chk_time_reg   <= '0;
            chk_proto_reg  <= '0;
            chk_src_reg    <= '0;
            chk_dst_reg    <= '0;
            cnt_reg        <= '0;
            hit1_found_reg <= 1'b0;
            hit1_idx_reg   <= '0;
            hit2_found_reg <= 1'b0;
            hit2_idx_reg   <= '0;
            res_dup_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_index_reg  <= '0;
            out_supp_reg   <= 1'b0;
        end
        else
        begin
            // config write
            if (cfg.valid && cfg.ready)
            begin
                window_reg <= cfg.dedup_window;
            end

            // rule valid bits
            if (rule_wr)
            begin
                ent_valid_reg[wr_addr] <= 1'b1;
            end

            // read pipeline tags
            rd_ok_reg   <= ent_valid_reg[cnt_reg];
            rd_idx_reg  <= cnt_reg;
            eval_en_reg <= (state_reg == S_SCAN);

            // first hit of each pass
            if (eval_en_reg)
            begin
                if (ent_p1 && !hit1_found_reg)
                begin
                    hit1_found_reg <= 1'b1;
                    hit1_idx_reg   <= rd_idx_reg;
                end
                if (ent_p2 && !hit2_found_reg)
                begin
                    hit2_found_reg <= 1'b1;
                    hit2_idx_reg   <= rd_idx_reg;
                end
            end

            // response taken
            if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_fire && (req.action == ACT_PKT))
                    begin
                        pkt_proto_reg <= req.proto;
                        pkt_src_reg   <= req.src_port;
                        pkt_dst_reg   <= req.dst_port;
                        pkt_time_reg  <= req.pkt_time;
                        state_reg     <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    prev_time_reg <= pkt_time_reg;
                    if (check_run)
                    begin
                        chk_time_reg  <= pkt_time_reg;
                        chk_proto_reg <= pkt_proto_reg;
                        chk_src_reg   <= pkt_src_reg;
                        chk_dst_reg   <= pkt_dst_reg;
                    end
                    res_dup_reg    <= is_dup;
                    hit1_found_reg <= 1'b0;
                    hit2_found_reg <= 1'b0;
                    cnt_reg        <= '0;
                    state_reg      <= is_dup ? S_OUT : S_SCAN;
                end
                S_SCAN:
                begin
                    if (cnt_reg == IDX_W'(NUM_RULES - 1))
                    begin
                        state_reg <= S_LAST;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_LAST:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_supp_reg  <= res_dup_reg;
                        out_index_reg <= res_dup_reg ? '0 : RIDX_W'(res_idx);
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    `PRCD_ASSERT_NOW(a_supp_index_zero, rsp.valid && rsp.suppressed, rsp.match_index == '0, "suppressed word carries a rule index")
    `PRCD_ASSERT_NEXT(a_pkt_to_load, req.valid && req.ready && (req.action == ACT_PKT), state_reg == S_LOAD, "accepted packet not registered")
    `PRCD_ASSERT_NOW(a_scan_range, state_reg == S_SCAN, 32'(cnt_reg) < NUM_RULES, "sweep address past the table")
    `PRCD_ASSERT_NEXT(a_hit1_kept, hit1_found_reg && (state_reg == S_SCAN || state_reg == S_LAST), hit1_found_reg && $stable(hit1_idx_reg), "first pass hit overwritten")
    `PRCD_ASSERT_NOW(a_eval_tracks_scan, eval_en_reg, state_reg == S_SCAN || state_reg == S_LAST, "entry evaluated outside the sweep")

endmodule

/* verif/tb_port_rule_classifier_dedup_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_port_rule_classifier_dedup_unit
// self-checking bench for the port rule classifier with duplicate suppression
// ----------------------------------------------------------------------------
// Rule writes and packet headers go in on the request channel. A local
// model of the rule table and the duplicate history predicts one result
// word per packet. Each result word is checked against the oldest
// prediction. Directed tests cover both match passes, wildcard ports and
// the dedup window edges. Random traffic then runs under several window
// settings and idle patterns on both channels.
// ----------------------------------------------------------------------------
module tb_port_rule_classifier_dedup_unit;
    import prcd_pkg::*;

    localparam int NUM_RULES     = 16;
    localparam int SETTLE_CYCLES = NUM_RULES + 12;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 432;

    // one request word as the bench sees it
    typedef struct {
        logic               action;
        logic [RIDX_W-1:0]  rule_index;
        logic [PROTO_W-1:0] proto;
        logic [PORT_W-1:0]  src_port;
        logic [PORT_W-1:0]  dst_port;
        logic [TIME_W-1:0]  pkt_time;
    } req_word_t;

    // one predicted result word
    typedef struct {
        logic [RIDX_W-1:0] match_index;
        logic              suppressed;
    } match_result_t;

    logic clk = 1'b0;
    logic rst_n;

    prcd_req_if req ();
    prcd_rsp_if rsp ();
    prcd_cfg_if cfg ();

    port_rule_classifier_dedup_unit #(
        .NUM_RULES (NUM_RULES)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    // model of the rule table and duplicate history
    logic [PROTO_W-1:0] tbl_proto [NUM_RULES];
    logic [PORT_W-1:0]  tbl_src   [NUM_RULES];
    logic [PORT_W-1:0]  tbl_dst   [NUM_RULES];
    logic [TIME_W-1:0]  prev_time;
    logic [TIME_W-1:0]  hist_time;
    logic [PROTO_W-1:0] hist_proto;
    logic [PORT_W-1:0]  hist_src;
    logic [PORT_W-1:0]  hist_dst;
    logic [TIME_W-1:0]  window;

    match_result_t match_results [$];

    // stimulus state
    int        src_idle_pct;
    int        sink_idle_pct;
    int        mismatch_count;
    int        cycle_count;
    int        n_pkts;
    int        n_rules;
    int        n_dups;
    int        n_windows;
    req_word_t last_pkt;
    bit        have_last;
    logic [PORT_W-1:0]  port_pool  [16];
    logic [PROTO_W-1:0] proto_pool [4];

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, match_results.size());
            $display("** port_rule_classifier_dedup_unit: FAILED **");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        rsp.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin : result_check
        match_result_t exp_r;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (match_results.size() == 0)
                report_mismatch($sformatf("unexpected result word idx %0d supp %0b",
                                          rsp.match_index, rsp.suppressed));
            else
            begin
                exp_r = match_results.pop_front();
                if (rsp.match_index !== exp_r.match_index)
                    report_mismatch($sformatf("match_index %0d, expected %0d",
                                              rsp.match_index, exp_r.match_index));
                if (rsp.suppressed !== exp_r.suppressed)
                    report_mismatch($sformatf("suppressed %0b, expected %0b",
                                              rsp.suppressed, exp_r.suppressed));
            end
        end
    end

    // update the model with one accepted word and queue its result
    task automatic predict_word(input req_word_t w);
        logic [TIME_W-1:0] diff;
        longint            gap;
        bit                dup;
        int                hit;
        match_result_t     r;
        if (w.action == ACT_RULE)
        begin
            if (w.rule_index < NUM_RULES)
            begin
                tbl_proto[w.rule_index] = w.proto;
                tbl_src[w.rule_index]   = w.src_port;
                tbl_dst[w.rule_index]   = w.dst_port;
            end
            n_rules++;
            return;
        end
        n_pkts++;
        diff      = w.pkt_time - prev_time;
        gap       = diff[TIME_W-1] ? longint'(diff) - 64'sd4294967296 : longint'(diff);
        prev_time = w.pkt_time;
        dup       = 1'b0;
        // duplicate check only runs when the gap fits the window
        if (gap <= longint'(window))
        begin
            dup = ((w.pkt_time - hist_time) <= window) && (w.proto == hist_proto) &&
                  (w.src_port == hist_src) && (w.dst_port == hist_dst) &&
                  (w.src_port != '0);
            hist_time  = w.pkt_time;
            hist_proto = w.proto;
            hist_src   = w.src_port;
            hist_dst   = w.dst_port;
        end
        if (dup)
        begin
            r.match_index = '0;
            r.suppressed  = 1'b1;
            n_dups++;
        end
        else
        begin
            // pass one: exact or wildcard ports, pass two: either port equal
            hit = -1;
            for (int k = 0; k < NUM_RULES; k++)
                if (hit < 0 && tbl_proto[k] == w.proto &&
                    (tbl_src[k] == '0 || tbl_src[k] == w.src_port) &&
                    (tbl_dst[k] == '0 || tbl_dst[k] == w.dst_port))
                    hit = k;
            for (int k = 0; k < NUM_RULES; k++)
                if (hit < 0 && tbl_proto[k] == w.proto &&
                    (tbl_src[k] == w.src_port || tbl_dst[k] == w.dst_port))
                    hit = k;
            if (hit < 0)
                hit = 0;
            r.match_index = hit[RIDX_W-1:0];
            r.suppressed  = 1'b0;
        end
        match_results.push_back(r);
    endtask

    // send one request word, with random idle cycles ahead of it
    task automatic send_word(input req_word_t w);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            @(negedge clk);
            req.valid <= 1'b0;
        end
        @(negedge clk);
        req.valid      <= 1'b1;
        req.action     <= w.action;
        req.rule_index <= w.rule_index;
        req.proto      <= w.proto;
        req.src_port   <= w.src_port;
        req.dst_port   <= w.dst_port;
        req.pkt_time   <= w.pkt_time;
        do @(posedge clk); while (!req.ready);
        predict_word(w);
    endtask

    task automatic send_rule(input logic [RIDX_W-1:0] idx, input logic [PROTO_W-1:0] p,
                             input logic [PORT_W-1:0] sp, input logic [PORT_W-1:0] dp);
        req_word_t w;
        w.action     = ACT_RULE;
        w.rule_index = idx;
        w.proto      = p;
        w.src_port   = sp;
        w.dst_port   = dp;
        w.pkt_time   = $urandom;
        send_word(w);
    endtask

    task automatic send_pkt(input logic [PROTO_W-1:0] p, input logic [PORT_W-1:0] sp,
                            input logic [PORT_W-1:0] dp, input logic [TIME_W-1:0] t);
        req_word_t w;
        w.action     = ACT_PKT;
        w.rule_index = RIDX_W'($urandom);
        w.proto      = p;
        w.src_port   = sp;
        w.dst_port   = dp;
        w.pkt_time   = t;
        send_word(w);
    endtask

    // drop valid, wait for every pending result, then let the block settle
    task automatic wait_idle();
        @(negedge clk);
        req.valid <= 1'b0;
        while (match_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write the dedup window while the block is idle
    task automatic write_window(input logic [TIME_W-1:0] value);
        wait_idle();
        @(negedge clk);
        cfg.valid        <= 1'b1;
        cfg.dedup_window <= value;
        do @(posedge clk); while (!cfg.ready);
        window = value;
        n_windows++;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    function automatic logic [PORT_W-1:0] pick_port();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return '0;
        else if (r < 65)
            return port_pool[$urandom_range(0, 15)];
        else
            return PORT_W'($urandom);
    endfunction

    function automatic logic [PROTO_W-1:0] pick_proto();
        if ($urandom_range(0, 99) < 80)
            return proto_pool[$urandom_range(0, 3)];
        else
            return PROTO_W'($urandom);
    endfunction

    // one random word: mostly packets, often repeats of the last packet
    task automatic gen_word(output req_word_t w);
        int r;
        w.rule_index = RIDX_W'($urandom);
        w.pkt_time   = $urandom;
        if ($urandom_range(0, 99) < 20)
        begin
            w.action   = ACT_RULE;
            w.proto    = pick_proto();
            w.src_port = pick_port();
            w.dst_port = pick_port();
            return;
        end
        w.action = ACT_PKT;
        if (have_last && $urandom_range(0, 99) < 35)
        begin
            w.proto    = last_pkt.proto;
            w.src_port = last_pkt.src_port;
            w.dst_port = last_pkt.dst_port;
        end
        else
        begin
            w.proto    = pick_proto();
            w.src_port = pick_port();
            w.dst_port = pick_port();
        end
        // time steps around the window, with jumps and steps backward
        if (have_last)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                w.pkt_time = $urandom;
            else if (r < 20)
                w.pkt_time = last_pkt.pkt_time - $urandom_range(0, 300);
            else if (r < 28)
                w.pkt_time = last_pkt.pkt_time + window + $urandom_range(0, 1);
            else if (window <= 1000)
                w.pkt_time = last_pkt.pkt_time + $urandom_range(0, 2 * window + 2);
            else
                w.pkt_time = last_pkt.pkt_time + $urandom_range(0, 1000);
        end
        last_pkt  = w;
        have_last = 1'b1;
    endtask

    // empty table after reset, extremes of every field
    task automatic test_after_reset();
        send_pkt(8'h00, 16'h0000, 16'h0000, 32'h0000_0000);
        send_pkt(8'h00, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    endtask

    // wildcard ports, first and second pass, no match
    task automatic test_rule_passes();
        send_rule(4'd15, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_rule(4'd3, 8'd6, 16'd80, 16'd0);
        send_rule(4'd5, 8'd6, 16'd0, 16'd443);
        send_rule(4'd1, 8'd17, 16'd53, 16'd53);
        send_pkt(8'hFF, 16'hFFFF, 16'hFFFF, 32'd100);
        send_pkt(8'd6, 16'd80, 16'd1234, 32'd200);
        send_pkt(8'd6, 16'd9, 16'd443, 32'd300);
        send_pkt(8'd17, 16'd53, 16'd99, 32'd400);
        send_pkt(8'd17, 16'd7, 16'd8, 32'd500);
        send_pkt(8'hFF, 16'd1, 16'hFFFF, 32'd600);
    endtask

    // duplicates, zero source port, gap outside window, backward time
    task automatic test_dedup_window();
        write_window(32'd100);
        send_pkt(8'd6, 16'd1000, 16'd2000, 32'd5000);
        send_pkt(8'd6, 16'd1000, 16'd2000, 32'd5050);
        send_pkt(8'd6, 16'd1000, 16'd2000, 32'd5100);
        send_pkt(8'd6, 16'd0, 16'd2000, 32'd5110);
        send_pkt(8'd6, 16'd0, 16'd2000, 32'd5111);
        // sender holds off until the block has drained
        wait_idle();
        send_pkt(8'd6, 16'd1000, 16'd2000, 32'd9000);
        wait_idle();
        send_pkt(8'd6, 16'd1000, 16'd2000, 32'd9010);
        send_pkt(8'd6, 16'd1000, 16'd2000, 32'd9005);
        write_window(32'hFFFF_FFFF);
        send_pkt(8'd1, 16'd1, 16'd1, 32'h0000_0000);
        send_pkt(8'd1, 16'd1, 16'd1, 32'h8000_0000);
        write_window(32'd0);
        send_pkt(8'd1, 16'd1, 16'd1, 32'h8000_0000);
    endtask

    // random traffic over four window settings
    task automatic test_random_traffic(input int src_pct, input int sink_pct);
        req_word_t w;
        logic [TIME_W-1:0] win;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (int seg = 0; seg < 4; seg++)
        begin
            case (seg)
                0: win = '0;
                1: win = $urandom_range(1, 300);
                2: win = $urandom;
                default: win = '1;
            endcase
            write_window(win);
            for (int i = 0; i < RANDOM_ITEMS / 4; i++)
            begin
                gen_word(w);
                send_word(w);
            end
        end
    endtask

    initial
    begin
        // known values on every input
        rst_n            = 1'b0;
        req.valid        = 1'b0;
        req.action       = ACT_RULE;
        req.rule_index   = '0;
        req.proto        = '0;
        req.src_port     = '0;
        req.dst_port     = '0;
        req.pkt_time     = '0;
        rsp.ready        = 1'b0;
        cfg.valid        = 1'b0;
        cfg.dedup_window = '0;
        cycle_count      = 0;
        mismatch_count   = 0;
        n_pkts           = 0;
        n_rules          = 0;
        n_dups           = 0;
        n_windows        = 0;
        have_last        = 1'b0;
        src_idle_pct     = 16;
        sink_idle_pct    = 66;

        // model reset state
        for (int k = 0; k < NUM_RULES; k++)
        begin
            tbl_proto[k] = '0;
            tbl_src[k]   = '0;
            tbl_dst[k]   = '0;
        end
        prev_time  = '0;
        hist_time  = '0;
        hist_proto = '0;
        hist_src   = '0;
        hist_dst   = '0;
        window     = '0;

        // value pools for random traffic
        proto_pool[0] = 8'd6;
        proto_pool[1] = 8'd17;
        proto_pool[2] = 8'd1;
        proto_pool[3] = 8'hFF;
        port_pool[0]  = 16'hFFFF;
        port_pool[1]  = 16'd1;
        for (int k = 2; k < 16; k++)
            port_pool[k] = (k < 8) ? PORT_W'($urandom_range(1, 1024)) : PORT_W'($urandom);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_after_reset();
        test_rule_passes();
        test_dedup_window();
        test_random_traffic(16, 66);
        test_random_traffic(66, 16);
        test_random_traffic(0, 0);

        wait_idle();
        if (match_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", match_results.size()));

        $display("covered %0d packets (%0d suppressed) and %0d rule writes",
                 n_pkts, n_dups, n_rules);
        $display("over %0d window settings and three idle patterns, %0d mismatches",
                 n_windows, mismatch_count);
        if (mismatch_count == 0)
            $display("** port_rule_classifier_dedup_unit: PASSED **");
        else
            $display("** port_rule_classifier_dedup_unit: FAILED **");
        $finish;
    end

endmodule
